FILE: src/fhc_pkg.sv
// Package for the frame header check and CRC decode block.
// Holds item kinds, status codes, register indexes and the CRC byte step.
// No dependencies.
package fhc_pkg;

  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNCATED = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_VERSION   = 4'd3,
    ST_HDRSIZE   = 4'd4,
    ST_RESERVED  = 4'd5,
    ST_TOPIC     = 4'd6,
    ST_PAYLOAD   = 4'd7,
    ST_FRAME     = 4'd8,
    ST_LENGTH    = 4'd9,
    ST_CRC       = 4'd10
  } status_e;

  localparam logic [2:0] REG_MAGIC   = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_TOPIC   = 3'd2;
  localparam logic [2:0] REG_PAYLOAD = 3'd3;
  localparam logic [2:0] REG_FRAME   = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [32:0] HDR_BYTES = 33'd56;
  localparam logic [32:0] IDX_MAX = {33{1'b1}};

  // One queue entry: a body byte and/or the frame status with captured fields.
  typedef struct packed {
    logic        has_body;
    logic        body_payload;
    logic [7:0]  body;
    logic        has_status;
    status_e     status;
    logic [7:0]  flags;
    logic [31:0] type_code;
    logic [63:0] schema;
    logic [63:0] seq;
    logic [63:0] sender;
    logic [63:0] stamp;
  } entry_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: src/fhc_front.sv
// Front part: parses the header, runs CRC, classifies each accepted byte.
// Depends on fhc_pkg.
module fhc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             rx_final_i,
  input  logic [31:0]      magic_i,
  input  logic [7:0]       version_i,
  input  logic [15:0]      topic_lim_i,
  input  logic [31:0]      payload_lim_i,
  input  logic [32:0]      frame_lim_i,
  output logic             push_o,
  output fhc_pkg::entry_t  entry_o
);

  logic [32:0] idx_q, idx_d, idx_inc;
  logic [31:0] crc_q, crc_d, shift_q, shift_d, type_q, type_d, exp_q, exp_d;
  logic [3:0]  err_q, err_d;
  logic [15:0] tlen_q, tlen_d;
  logic [31:0] plen_q, plen_d;
  logic [7:0]  flags_q, flags_d;
  logic [63:0] wide_q [4];
  logic [63:0] wide_d [4];
  logic [32:0] total;
  logic [32:0] total_new;
  logic [32:0] body_off;
  logic [1:0]  wk;
  logic        in_hdr;

  function automatic logic [32:0] HDR_TOTAL(input logic [15:0] t, input logic [31:0] p);
    return fhc_pkg::HDR_BYTES + {17'd0, t} + {1'b0, p};
  endfunction

  assign total     = HDR_TOTAL(tlen_q, plen_q);
  assign total_new = HDR_TOTAL(tlen_q, shift_d);
  assign in_hdr    = idx_q < fhc_pkg::HDR_BYTES;
  assign idx_inc   = (idx_q != fhc_pkg::IDX_MAX) ? idx_q + 33'd1 : idx_q;
  assign body_off  = idx_q - fhc_pkg::HDR_BYTES;
  assign wk        = 2'((idx_q[5:0] - 6'd20) >> 3);

  always_comb begin
    idx_d = idx_q; crc_d = crc_q; shift_d = shift_q; err_d = err_q;
    tlen_d = tlen_q; plen_d = plen_q; exp_d = exp_q; flags_d = flags_q;
    type_d = type_q; wide_d = wide_q;
    push_o = 1'b0;
    entry_o = '0;
    if (in_fire_i) begin
      if (in_hdr) begin
        shift_d = {shift_q[23:0], rx_byte_i};
        unique case (idx_q[5:0])
          6'd3: if (shift_d != magic_i && err_q == 4'd0) err_d = fhc_pkg::ST_MAGIC;
          6'd4: if (rx_byte_i != version_i && err_q == 4'd0) err_d = fhc_pkg::ST_VERSION;
          6'd5: flags_d = rx_byte_i;
          6'd7: if (shift_d[15:0] != 16'd56 && err_q == 4'd0) err_d = fhc_pkg::ST_HDRSIZE;
          6'd9: tlen_d = shift_d[15:0];
          6'd11: begin
            if (err_q == 4'd0) begin
              if (shift_d[15:0] != 16'd0) err_d = fhc_pkg::ST_RESERVED;
              else if (tlen_q > topic_lim_i) err_d = fhc_pkg::ST_TOPIC;
            end
          end
          6'd15: begin
            plen_d = shift_d;
            if (err_q == 4'd0) begin
              if (shift_d > payload_lim_i) err_d = fhc_pkg::ST_PAYLOAD;
              else if (total_new > frame_lim_i) err_d = fhc_pkg::ST_FRAME;
            end
          end
          default: begin
            if (idx_q[5:0] >= 6'd16 && idx_q[5:0] < 6'd20)
              type_d = {type_q[23:0], rx_byte_i};
            else if (idx_q[5:0] >= 6'd20 && idx_q[5:0] < 6'd52)
              wide_d[wk] = {wide_q[wk][55:0], rx_byte_i};
            else if (idx_q[5:0] >= 6'd52)
              exp_d = {exp_q[23:0], rx_byte_i};
          end
        endcase
      end else begin
        crc_d = fhc_pkg::crc_step(crc_q, rx_byte_i);
        if (err_q == 4'd0 && idx_q < total) begin
          entry_o.has_body     = 1'b1;
          entry_o.body_payload = !(body_off < {17'd0, tlen_q});
          entry_o.body         = rx_byte_i;
        end
      end
      idx_d = idx_inc;
      if (rx_final_i) begin
        entry_o.has_status = 1'b1;
        if (idx_inc < fhc_pkg::HDR_BYTES) entry_o.status = fhc_pkg::ST_TRUNCATED;
        else if (err_d != 4'd0) entry_o.status = fhc_pkg::status_e'(err_d);
        else if (idx_inc != HDR_TOTAL(tlen_d, plen_d)) entry_o.status = fhc_pkg::ST_LENGTH;
        else if (~crc_d != exp_d) entry_o.status = fhc_pkg::ST_CRC;
        else entry_o.status = fhc_pkg::ST_OK;
        entry_o.flags     = flags_d;
        entry_o.type_code = type_d;
        entry_o.schema    = wide_d[0];
        entry_o.seq       = wide_d[1];
        entry_o.sender    = wide_d[2];
        entry_o.stamp     = wide_d[3];
        // Drop all frame state after the status.
        idx_d = '0; crc_d = '1; shift_d = '0; err_d = '0; tlen_d = '0; plen_d = '0;
        exp_d = '0; flags_d = '0; type_d = '0;
        for (int k = 0; k < 4; k++) wide_d[k] = '0;
      end
      push_o = entry_o.has_body | entry_o.has_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; crc_q <= '1; shift_q <= '0; err_q <= '0; tlen_q <= '0;
      plen_q <= '0; exp_q <= '0; flags_q <= '0; type_q <= '0;
      for (int k = 0; k < 4; k++) wide_q[k] <= '0;
    end else begin
      idx_q <= idx_d; crc_q <= crc_d; shift_q <= shift_d; err_q <= err_d;
      tlen_q <= tlen_d; plen_q <= plen_d; exp_q <= exp_d; flags_q <= flags_d;
      type_q <= type_d; wide_q <= wide_d;
    end
  end

endmodule

FILE: src/fhc_back.sv
// Back part: short entry queue and output sequencer that splits an entry
// into a body item and a status item. Depends on fhc_pkg.
module fhc_back #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fhc_pkg::entry_t  entry_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       item_kind_o,
  output logic [7:0]       body_byte_o,
  output logic [3:0]       frame_status_o,
  output logic [7:0]       frame_flags_o,
  output logic [31:0]      type_code_o,
  output logic [63:0]      schema_digest_o,
  output logic [63:0]      seq_number_o,
  output logic [63:0]      sender_id_o,
  output logic [63:0]      send_stamp_o,
  output logic             item_last_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  fhc_pkg::entry_t mem_q [Depth];
  logic [AW-1:0] rd_q, wr_q;
  logic [AW:0]   cnt_q;
  logic          body_done_q;
  logic          pop, fire, show_body;
  fhc_pkg::entry_t head;

  assign head        = mem_q[rd_q];
  assign space_o     = cnt_q < (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign fire        = out_valid_o && out_ready_i;
  assign show_body   = head.has_body && !body_done_q;
  assign pop         = fire && (!show_body || !head.has_status);

  always_comb begin
    item_kind_o     = show_body ? (head.body_payload ? fhc_pkg::KIND_PAYLOAD
                                                     : fhc_pkg::KIND_TOPIC)
                                : fhc_pkg::KIND_STATUS;
    body_byte_o     = show_body ? head.body : 8'd0;
    frame_status_o  = show_body ? 4'd0 : head.status;
    frame_flags_o   = show_body ? 8'd0 : head.flags;
    type_code_o     = show_body ? 32'd0 : head.type_code;
    schema_digest_o = show_body ? 64'd0 : head.schema;
    seq_number_o    = show_body ? 64'd0 : head.seq;
    sender_id_o     = show_body ? 64'd0 : head.sender;
    send_stamp_o    = show_body ? 64'd0 : head.stamp;
    item_last_o     = !show_body;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0; body_done_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop);
      if (pop) body_done_q <= 1'b0;
      else if (fire) body_done_q <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("queue overflow");
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_last_o |-> item_kind_o == fhc_pkg::KIND_STATUS)
    else $error("last without status");
  a_body_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !item_last_o |-> frame_status_o == 4'd0 && type_code_o == 32'd0)
    else $error("body item carries fields");
endmodule

FILE: src/frame_header_check_and_crc_decode.sv
// Top level of the frame header check and CRC decode block.
// Depends on fhc_pkg, fhc_front and fhc_back.
//
// Takes one frame byte per transfer, rx_final_i on the last. The front parses
// the 56-byte big-endian header, keeps the first header error and runs CRC32
// over the body, one byte per cycle; it accepts a byte every cycle while the
// entry queue (Depth entries) has room. The back emits topic/payload bytes
// and one status item per frame; a final byte that also carries a body byte
// gives a body item and then a status item, so while the output is ready the
// sustained rate is one byte per cycle except for frames ending in a body
// byte. Configuration writes take effect at once; write them while idle.
module frame_header_check_and_crc_decode #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_final_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  body_byte_o,
  output logic [3:0]  frame_status_o,
  output logic [7:0]  frame_flags_o,
  output logic [31:0] type_code_o,
  output logic [63:0] schema_digest_o,
  output logic [63:0] seq_number_o,
  output logic [63:0] sender_id_o,
  output logic [63:0] send_stamp_o,
  output logic        item_last_o
);

  logic [31:0] magic_q, plim_q;
  logic [7:0]  ver_q;
  logic [15:0] tlim_q;
  logic [32:0] flim_q;
  logic        space, push, in_fire;
  fhc_pkg::entry_t entry;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign in_fire     = in_valid_i && in_ready_o;

  // Register file; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= 32'd0; ver_q <= 8'd1; tlim_q <= 16'hFFFF;
      plim_q <= 32'hFFFFFFFF; flim_q <= 33'd4295032886;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fhc_pkg::REG_MAGIC:   magic_q <= cfg_data_i[31:0];
        fhc_pkg::REG_VERSION: ver_q   <= cfg_data_i[7:0];
        fhc_pkg::REG_TOPIC:   tlim_q  <= cfg_data_i[15:0];
        fhc_pkg::REG_PAYLOAD: plim_q  <= cfg_data_i[31:0];
        fhc_pkg::REG_FRAME:   flim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fhc_front u_front (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .rx_byte_i, .rx_final_i,
    .magic_i(magic_q), .version_i(ver_q), .topic_lim_i(tlim_q),
    .payload_lim_i(plim_q), .frame_lim_i(flim_q), .push_o(push), .entry_o(entry)
  );

  fhc_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni, .push_i(push), .entry_i(entry), .space_o(space),
    .out_valid_o, .out_ready_i, .item_kind_o, .body_byte_o, .frame_status_o,
    .frame_flags_o, .type_code_o, .schema_digest_o, .seq_number_o, .sender_id_o,
    .send_stamp_o, .item_last_o
  );

endmodule

FILE: test/tb_frame_header_check_and_crc_decode.sv
// Testbench for frame_header_check_and_crc_decode: builds frames, predicts the
// topic/payload bytes and status of each and checks every output transfer.
// Depends on fhc_pkg and the block under test.
module tb_frame_header_check_and_crc_decode;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output item.
  typedef struct {
    fhc_pkg::kind_e kind;
    logic [7:0]  body;
    logic [3:0]  status;
    logic [7:0]  flags;
    logic [31:0] type_code;
    logic [63:0] wide [4];
    logic        last;
  } out_item_t;

  // Frame decoder prediction and the store of items still to come out.
  class frame_scoreboard;
    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    logic [15:0] topic_reg;
    logic [31:0] payload_reg;
    logic [32:0] frame_reg;
    logic [32:0] pos;
    logic [31:0] crc;
    logic [31:0] shift;
    logic [3:0]  hdr_err;
    logic [15:0] topic_len;
    logic [31:0] payload_len;
    logic [31:0] crc_rx;
    logic [7:0]  flags;
    logic [31:0] type_code;
    logic [63:0] wide [4];
    out_item_t   pending [$];
    int          errors;
    int          checked;
    int          frames;

    function void reset_regs();
      magic_reg = '0;
      version_reg = 8'd1;
      topic_reg = 16'hFFFF;
      payload_reg = 32'hFFFF_FFFF;
      frame_reg = 33'd4295032886;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      crc = 32'hFFFF_FFFF;
      shift = '0;
      hdr_err = fhc_pkg::ST_OK;
      topic_len = '0;
      payload_len = '0;
      crc_rx = '0;
      flags = '0;
      type_code = '0;
      for (int k = 0; k < 4; k++) wide[k] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [32:0] val);
      case (idx)
        fhc_pkg::REG_MAGIC:   magic_reg = val[31:0];
        fhc_pkg::REG_VERSION: version_reg = val[7:0];
        fhc_pkg::REG_TOPIC:   topic_reg = val[15:0];
        fhc_pkg::REG_PAYLOAD: payload_reg = val[31:0];
        fhc_pkg::REG_FRAME:   frame_reg = val;
        default: ;
      endcase
    endfunction

    function void flag(fhc_pkg::status_e code);
      if (hdr_err == fhc_pkg::ST_OK) hdr_err = code;
    endfunction

    function logic [33:0] total_len();
      return 34'd56 + 34'(topic_len) + 34'(payload_len);
    endfunction

    function void header_byte(int p, logic [7:0] b);
      shift = {shift[23:0], b};
      if (p == 3 && shift != magic_reg) flag(fhc_pkg::ST_MAGIC);
      else if (p == 4 && b != version_reg) flag(fhc_pkg::ST_VERSION);
      else if (p == 5) flags = b;
      else if (p == 7 && shift[15:0] != 16'd56) flag(fhc_pkg::ST_HDRSIZE);
      else if (p == 9) topic_len = shift[15:0];
      else if (p == 11) begin
        if (shift[15:0] != 0) flag(fhc_pkg::ST_RESERVED);
        if (topic_len > topic_reg) flag(fhc_pkg::ST_TOPIC);
      end else if (p == 15) begin
        payload_len = shift;
        if (payload_len > payload_reg) flag(fhc_pkg::ST_PAYLOAD);
        if (total_len() > 34'(frame_reg)) flag(fhc_pkg::ST_FRAME);
      end else if (p >= 16 && p < 20) type_code = {type_code[23:0], b};
      else if (p >= 20 && p < 52) begin
        int k;
        k = (p - 20) >> 3;
        wide[k] = {wide[k][55:0], b};
      end else if (p >= 52) crc_rx = {crc_rx[23:0], b};
    endfunction

    // Note an accepted byte and queue the items it causes.
    function void note_byte(logic [7:0] b, logic fin);
      out_item_t it;
      logic [32:0] idx;
      idx = pos;
      if (idx < 56) header_byte(int'(idx), b);
      else begin
        crc = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (32'hEDB88320 & {32{crc[0]}});
        if (hdr_err == fhc_pkg::ST_OK && 34'(idx) < total_len()) begin
          it.kind = (idx - 56 < 33'(topic_len)) ? fhc_pkg::KIND_TOPIC
                                                 : fhc_pkg::KIND_PAYLOAD;
          it.body = b;
          it.status = '0;
          it.flags = '0;
          it.type_code = '0;
          for (int k = 0; k < 4; k++) it.wide[k] = '0;
          it.last = 1'b0;
          pending.push_back(it);
        end
      end
      if (pos != {33{1'b1}}) pos++;
      if (fin) begin
        it.kind = fhc_pkg::KIND_STATUS;
        it.body = '0;
        if (pos < 56) it.status = fhc_pkg::ST_TRUNCATED;
        else if (hdr_err != fhc_pkg::ST_OK) it.status = hdr_err;
        else if (34'(pos) != total_len()) it.status = fhc_pkg::ST_LENGTH;
        else if (~crc != crc_rx) it.status = fhc_pkg::ST_CRC;
        else it.status = fhc_pkg::ST_OK;
        it.flags = flags;
        it.type_code = type_code;
        for (int k = 0; k < 4; k++) it.wide[k] = wide[k];
        it.last = 1'b1;
        pending.push_back(it);
        frames++;
        clear_frame();
      end
    endfunction

    function void mism(string name, logic [63:0] e, logic [63:0] a);
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    endfunction

    // Compare one output transfer with the oldest expected item.
    function void check_item(logic [1:0] kind, logic [7:0] body, logic [3:0] st,
                             logic [7:0] fl, logic [31:0] ty, logic [63:0] w0,
                             logic [63:0] w1, logic [63:0] w2, logic [63:0] w3,
                             logic last);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected output item, kind %0d", kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (kind != e.kind) mism("item_kind", e.kind, kind);
      if (body != e.body) mism("body_byte", e.body, body);
      if (st != e.status) mism("frame_status", e.status, st);
      if (fl != e.flags) mism("frame_flags", e.flags, fl);
      if (ty != e.type_code) mism("type_code", e.type_code, ty);
      if (w0 != e.wide[0]) mism("schema_digest", e.wide[0], w0);
      if (w1 != e.wide[1]) mism("seq_number", e.wide[1], w1);
      if (w2 != e.wide[2]) mism("sender_id", e.wide[2], w2);
      if (w3 != e.wide[3]) mism("send_stamp", e.wide[3], w3);
      if (last != e.last) mism("item_last", e.last, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        rx_final_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [32:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  item_kind_o;
  logic [7:0]  body_byte_o;
  logic [3:0]  frame_status_o;
  logic [7:0]  frame_flags_o;
  logic [31:0] type_code_o;
  logic [63:0] schema_digest_o;
  logic [63:0] seq_number_o;
  logic [63:0] sender_id_o;
  logic [63:0] send_stamp_o;
  logic        item_last_o;

  frame_scoreboard sb;
  bit  calm;        // suppress idling on both sides while set
  int  bytes_sent;
  logic [7:0] frame_buf [$];

  frame_header_check_and_crc_decode DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: stall at random, check every transfer at the edge it happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_item(item_kind_o, body_byte_o, frame_status_o, frame_flags_o,
                      type_code_o, schema_digest_o, seq_number_o, sender_id_o,
                      send_stamp_o, item_last_o);
      out_ready_i <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Write one register; the block must be idle. Valid is dropped before the task returns.
  task automatic write_reg(logic [2:0] idx, logic [32:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one byte; random gaps come before valid rises, never after.
  task automatic send_byte(logic [7:0] b, logic fin);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    rx_final_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Drop valid, wait until every expected item has come, then let the pipe drain.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void put_be(int n, logic [63:0] v);
    for (int i = n - 1; i >= 0; i--) frame_buf.push_back(v[8*i +: 8]);
  endfunction

  // Build a frame: fault selects one corruption (0 none).
  function automatic void build_frame(int tlen, int plen, int fault);
    logic [31:0] c;
    logic [7:0]  body [$];
    frame_buf.delete();
    for (int i = 0; i < tlen + plen; i++) body.push_back(8'($urandom));
    c = 32'hFFFF_FFFF;
    foreach (body[i]) begin
      c = c ^ {24'd0, body[i]};
      for (int k = 0; k < 8; k++) c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
    end
    c = ~c;
    put_be(4, fault == 1 ? sb.magic_reg ^ (32'h1 << $urandom_range(31)) : sb.magic_reg);
    put_be(1, fault == 2 ? sb.version_reg + 8'd1 : sb.version_reg);
    put_be(1, $urandom);
    put_be(2, fault == 3 ? 16'd57 : 16'd56);
    put_be(2, tlen);
    put_be(2, fault == 4 ? 16'h0100 : 16'h0);
    put_be(4, plen);
    put_be(4, $urandom);
    for (int k = 0; k < 4; k++) put_be(8, {$urandom, $urandom});
    put_be(4, fault == 5 ? c ^ 32'h8000_0001 : c);
    foreach (body[i]) frame_buf.push_back(body[i]);
    if (fault == 6) frame_buf.push_back(8'($urandom));
    if (fault == 7 && frame_buf.size() > 56) void'(frame_buf.pop_back());
    if (fault == 8) while (frame_buf.size() > 1 + $urandom_range(54))
      void'(frame_buf.pop_back());
  endfunction

  initial begin
    #2ms;
    $display("tb_frame_header_check_and_crc_decode: errors");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_regs();
    calm = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default registers, then every register at extremes.
    build_frame(2, 3, 0);
    send_frame();
    send_byte(8'hFF, 1'b1);       // one-byte truncated frame
    drain();
    write_reg(fhc_pkg::REG_MAGIC, 33'hFFFF_FFFF);
    write_reg(fhc_pkg::REG_VERSION, 33'hFF);
    write_reg(fhc_pkg::REG_TOPIC, 33'd0);
    write_reg(fhc_pkg::REG_PAYLOAD, 33'd0);
    write_reg(fhc_pkg::REG_FRAME, 33'd56);
    write_reg(3'd7, 33'h1_2345_6789);   // unused index, ignored
    build_frame(0, 0, 0);
    send_frame();                  // empty body, ok
    build_frame(1, 0, 0);
    send_frame();                  // topic over limit
    drain();
    write_reg(fhc_pkg::REG_TOPIC, 33'd3);
    write_reg(fhc_pkg::REG_PAYLOAD, 33'd4);
    write_reg(fhc_pkg::REG_FRAME, 33'd60);
    build_frame(0, 5, 0);
    send_frame();                  // payload over limit
    build_frame(3, 2, 0);
    send_frame();                  // frame over limit
    for (int f = 1; f <= 8; f++) begin
      build_frame(2, 2, f);
      send_frame();
    end
    drain();

    // Random: tight limits with no idling, then the widest limits.
    calm = 1'b1;
    for (int ph = 0; ph < 2; ph++) begin
      int base;
      base = bytes_sent;
      write_reg(fhc_pkg::REG_MAGIC, 33'($urandom));
      write_reg(fhc_pkg::REG_VERSION, 33'($urandom_range(255)));
      write_reg(fhc_pkg::REG_TOPIC, ph == 1 ? 33'hFFFF : 33'($urandom_range(12)));
      write_reg(fhc_pkg::REG_PAYLOAD, ph == 1 ? 33'hFFFF_FFFF : 33'($urandom_range(20)));
      write_reg(fhc_pkg::REG_FRAME, ph == 1 ? 33'h1_FFFF_FFFF
                                            : 33'(56 + $urandom_range(30)));
      while (bytes_sent - base < 40) begin
        build_frame($urandom_range(10), $urandom_range(16),
                    $urandom_range(99) < 70 ? 0 : $urandom_range(1, 8));
        send_frame();
        if ($urandom_range(9) == 0) drain();   // sender holds until all is out
      end
      drain();
      calm = 1'b0;
    end

    $display("Covered %0d bytes in %0d frames, %0d output items checked.",
             bytes_sent, sb.frames, sb.checked);
    $display("Checked header faults, limits, truncation, length and CRC errors.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_frame_header_check_and_crc_decode: clean");
    else
      $display("tb_frame_header_check_and_crc_decode: errors");
    $finish;
  end
endmodule
